[hdl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; users include this file by its bare name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/msp_pkg.sv]
// types, codes and sizing constants of the multi stack plate buffer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package msp_pkg;

    localparam int NUM_STACKS_DEF = 64;
    localparam int MAX_DEPTH_DEF  = 16;

    localparam int CMD_W    = 2;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 6;
    localparam int CAP_W    = 5;
    localparam int STACK_SEL_W = 10; // holds any stack number up to the largest bank

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_PLATE
    } t_fsm;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] push_value;
        logic [IDX_W-1:0]        stack_index;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] pop_value;
        t_status                 status;
    } t_out_item;

    typedef struct packed {
        logic                   hit;
        logic [STACK_SEL_W-1:0] stack;
    } t_select;

endpackage

[hdl/msp_select.sv]
// target stack selection: priority encoders over the full and non-empty flags
// depends on msp_pkg
`timescale 1ns / 1ps

module msp_select import msp_pkg::*; #(
    parameter int NUM_STACKS = NUM_STACKS_DEF
) (
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [IDX_W-1:0]      i_stack_index,
    input  logic [NUM_STACKS-1:0] i_full,
    input  logic [NUM_STACKS-1:0] i_nonempty,
    output t_select               o_sel
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    logic                   push_hit;
    logic [STACK_SEL_W-1:0] push_stack;
    logic                   pop_hit;
    logic [STACK_SEL_W-1:0] pop_stack;
    logic                   at_ok;
    logic [SW-1:0]          at_idx;

    // lowest stack that still has room
    always_comb begin
        push_hit   = 1'b0;
        push_stack = '0;
        for (int s = NUM_STACKS - 1; s >= 0; s--) begin
            if (!i_full[s]) begin
                push_hit   = 1'b1;
                push_stack = STACK_SEL_W'(s);
            end
        end
    end

    // highest stack holding a plate
    always_comb begin
        pop_hit   = 1'b0;
        pop_stack = '0;
        for (int s = 0; s < NUM_STACKS; s++) begin
            if (i_nonempty[s]) begin
                pop_hit   = 1'b1;
                pop_stack = STACK_SEL_W'(s);
            end
        end
    end

    assign at_idx = SW'(i_stack_index);
    assign at_ok  = (32'(i_stack_index) < NUM_STACKS) && i_nonempty[at_idx];

    always_comb begin
        o_sel = '0;
        case (i_cmd)
            CMD_PUSH: begin
                o_sel.hit   = push_hit;
                o_sel.stack = push_stack;
            end
            CMD_POP: begin
                o_sel.hit   = pop_hit;
                o_sel.stack = pop_stack;
            end
            CMD_POP_AT: begin
                o_sel.hit   = at_ok;
                o_sel.stack = STACK_SEL_W'(i_stack_index);
            end
            default: begin
                o_sel.hit   = 1'b0;
                o_sel.stack = '0;
            end
        endcase
    end

endmodule

[hdl/msp_core.sv]
// command sequencer with the fill count memory and the plate store
// depends on msp_pkg and msp_select
`timescale 1ns / 1ps

module msp_core import msp_pkg::*; #(
    parameter int NUM_STACKS = NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    input  logic             i_cfg_valid,
    input  logic [CAP_W-1:0] i_cfg_data,
    output logic             o_res_valid,
    output t_out_item        o_res,
    input  logic             i_res_ready
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int AW = SW + DW;
    localparam int PD = NUM_STACKS * (2 ** DW);

    t_fsm                    r_state;
    t_fsm                    n_state;
    logic [CAP_W-1:0]        r_cap;
    logic [NUM_STACKS-1:0]   r_full;
    logic [NUM_STACKS-1:0]   r_nonempty;

    logic [CMD_W-1:0]        r_cmd;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_hit;
    logic [SW-1:0]           r_stack;

    logic [CW-1:0]           r_cnt_mem [NUM_STACKS];
    logic [CW-1:0]           r_cnt_q;
    logic signed [VAL_W-1:0] r_plate_mem [PD];
    logic signed [VAL_W-1:0] r_plate_q;

    logic                    r_sweep_rd;
    logic                    r_sweep_chk;
    logic [SW-1:0]           r_sweep_ptr;
    logic [SW-1:0]           r_sweep_at;

    t_select                 sel;
    logic [CW-1:0]           cap_eff;
    logic                    accept;
    logic                    busy;
    logic                    is_push;
    logic                    calc_act;
    logic [CW-1:0]           cnt_cur;
    logic [CW-1:0]           cnt_next;
    logic [AW-1:0]           plate_addr;
    logic                    cnt_re;
    logic [SW-1:0]           cnt_rd_addr;

    msp_select #(
        .NUM_STACKS (NUM_STACKS)
    ) u_select (
        .i_cmd         (i_in_data.cmd),
        .i_stack_index (i_in_data.stack_index),
        .i_full        (r_full),
        .i_nonempty    (r_nonempty),
        .o_sel         (sel)
    );

    // zero acts as one, anything above the stack depth saturates
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if (32'(r_cap) > MAX_DEPTH) begin
            cap_eff = CW'(MAX_DEPTH);
        end else begin
            cap_eff = CW'(r_cap);
        end
    end

    assign busy     = r_sweep_rd || r_sweep_chk;
    assign accept   = i_in_valid && o_in_ready;
    assign is_push  = (r_cmd == CMD_PUSH);
    assign calc_act = (r_state == S_CALC) && r_hit;

    // a stack without its non-empty flag holds no plates, whatever the memory says
    assign cnt_cur    = r_nonempty[r_stack] ? r_cnt_q : '0;
    assign cnt_next   = is_push ? CW'(cnt_cur + CW'(1)) : CW'(cnt_cur - CW'(1));
    assign plate_addr = {r_stack, (is_push ? cnt_cur[DW-1:0] : cnt_next[DW-1:0])};

    assign cnt_re      = accept || r_sweep_rd;
    assign cnt_rd_addr = r_sweep_rd ? r_sweep_ptr : SW'(sel.stack);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_PLATE;
            end
            S_PLATE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !busy && !i_cfg_valid;
            end
            S_PLATE: begin
                o_res_valid = 1'b1;
                if (r_hit) begin
                    o_res.status    = ST_OK;
                    o_res.pop_value = is_push ? '0 : r_plate_q;
                end else begin
                    o_res.status    = is_push ? ST_FULL : ST_EMPTY;
                    o_res.pop_value = '0;
                end
            end
            default: begin
                o_in_ready  = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_full      <= '0;
            r_nonempty  <= '0;
            r_sweep_rd  <= 1'b0;
            r_sweep_chk <= 1'b0;
            r_sweep_ptr <= '0;
            r_sweep_at  <= '0;
        end else begin
            r_state <= n_state;
            if (calc_act) begin
                r_full[r_stack]     <= (cnt_next >= cap_eff);
                r_nonempty[r_stack] <= (cnt_next != '0);
            end
            // full flags are rebuilt from the counts after a capacity change
            r_sweep_chk <= r_sweep_rd;
            r_sweep_at  <= r_sweep_ptr;
            if (r_sweep_chk) begin
                r_full[r_sweep_at] <= r_nonempty[r_sweep_at] && (r_cnt_q >= cap_eff);
            end
            if (i_cfg_valid) begin
                r_cap       <= i_cfg_data;
                r_sweep_rd  <= 1'b1;
                r_sweep_ptr <= '0;
            end else if (r_sweep_rd) begin
                if (r_sweep_ptr == SW'(NUM_STACKS - 1)) begin
                    r_sweep_rd <= 1'b0;
                end else begin
                    r_sweep_ptr <= r_sweep_ptr + SW'(1);
                end
            end
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_in_data.cmd;
            r_value <= i_in_data.push_value;
            r_hit   <= sel.hit;
            r_stack <= SW'(sel.stack);
        end
    end

    // fill count memory
    always_ff @(posedge i_clk) begin
        if (calc_act) begin
            r_cnt_mem[r_stack] <= cnt_next;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[cnt_rd_addr];
        end
    end

    // plate store
    always_ff @(posedge i_clk) begin
        if (calc_act && is_push) begin
            r_plate_mem[plate_addr] <= r_value;
        end
        if (calc_act && !is_push) begin
            r_plate_q <= r_plate_mem[plate_addr];
        end
    end

endmodule

[hdl/multi_stack_plate_buffer_unit.sv]
// Bank of NUM_STACKS stacks, MAX_DEPTH plates deep, sharing one plate store. Push goes to
// the lowest stack below capacity, pop to the highest non-empty stack, pop-at-index to the
// named stack; each command returns one result with a value and a status. A command is
// taken only once the previous one is through: the core reads the fill count memory,
// then reads or writes the plate store, then hands the result to the output register,
// which lets the next command enter while the result waits. After a capacity write the
// block takes no command while it rescans the fill count memory to rebuild the full
// flags. The capacity port is always ready.
// depends on msp_pkg, msp_core and assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module multi_stack_plate_buffer_unit import msp_pkg::*; #(
    parameter int NUM_STACKS = NUM_STACKS_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      res_valid;
    t_out_item res;
    logic      res_take;

    assign o_cfg_ready = 1'b1;

    msp_core #(
        .NUM_STACKS (NUM_STACKS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_take)
    );

    // output register takes a new result once the old one has left
    assign res_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_NEXT(a_one_cmd_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "command accepted while previous one still in flight")
    `ASSERT_NEXT(a_cfg_blocks_intake, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !o_in_ready, "command intake open during flag rescan")
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, res_valid && !res_take, res_valid, "result dropped while output register was full")
    `ASSERT_SAME(a_fail_zero_value, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), o_out_data.pop_value == '0, "failed command returned a nonzero value")

endmodule
